FILE: hw/rtl/length_framed_deframer_macros.svh
// ----------------------------------------------------------------------------
// length_framed_deframer_macros
// Assertion macros shared by the deframer modules; empty with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef LENGTH_FRAMED_DEFRAMER_MACROS_SVH
`define LENGTH_FRAMED_DEFRAMER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define LFD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfd assertion failed");
// next-cycle implication
`define LFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfd assertion failed");
`else
`define LFD_ASSERT_NOW(label, clk, rst, ante, cons)
`define LFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/lfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfd_pkg
// Shared types and constants of the length framed deframer.
// ----------------------------------------------------------------------------
package lfd_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_FRAME    = 2'd0,
    KIND_BAD_END  = 2'd1,
    KIND_OVERSIZE = 2'd2
  } kind_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MARK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;

  // configuration reset values
  localparam logic [7:0] START_MARK_RST  = 8'hAA;
  localparam logic [7:0] END_MARK_RST    = 8'h55;
  localparam logic [5:0] MAX_PAYLOAD_RST = 6'd59;

  // offset from the length to the end byte's address in the frame store
  localparam logic [7:0] HDR_END_OFFSET = 8'd4;

  // job handed from the parser to the emitter
  typedef struct packed {
    logic  valid;
    kind_t kind;
  } job_t;

endpackage

FILE: hw/rtl/lfd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/lfd_parser.sv
`timescale 1ns / 1ps
`include "length_framed_deframer_macros.svh"
// ----------------------------------------------------------------------------
// lfd_parser
// Hunts for the start mark, checks the length, writes frame bytes to the
// frame store and hands a finished frame or a drop status to the emitter.
// ----------------------------------------------------------------------------
module lfd_parser #(
  parameter int unsigned FRAME_BYTES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [7:0]                     rx_byte,
  input  logic [7:0]                     start_mark,
  input  logic [7:0]                     end_mark,
  input  logic [5:0]                     max_payload,
  output logic                           wr_en,
  output logic [$clog2(FRAME_BYTES)-1:0] wr_addr,
  output logic [7:0]                     wr_data,
  output lfd_pkg::job_t                  job,
  output logic [$clog2(FRAME_BYTES)-1:0] job_last_addr
);

  localparam int unsigned AW = $clog2(FRAME_BYTES);
  localparam logic [7:0] BODY_LIMIT = 8'(FRAME_BYTES - 5);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_BODY
  } phase_t;

  phase_t        phase;
  logic [AW-1:0] byte_count;
  logic [AW-1:0] last_addr;
  logic [7:0]    len_lo;
  logic [7:0]    limit;
  logic          oversize;
  logic          frame_done;

  // effective length limit and oversize check on the high length byte
  always_comb begin
    limit = ({2'b00, max_payload} > BODY_LIMIT) ? BODY_LIMIT : {2'b00, max_payload};
    oversize = (rx_byte != 8'd0) || (len_lo > limit);
    frame_done = (phase == PH_BODY) && (byte_count == last_addr);
  end

  // every kept byte goes to the store at the running count
  assign wr_en   = accept && ((phase != PH_HUNT) || (rx_byte == start_mark));
  assign wr_addr = byte_count;
  assign wr_data = rx_byte;

  // job request on the beat that completes or drops a frame
  always_comb begin
    job.valid = 1'b0;
    job.kind  = lfd_pkg::KIND_FRAME;
    if (accept && (phase == PH_LEN_HI) && oversize) begin
      job.valid = 1'b1;
      job.kind  = lfd_pkg::KIND_OVERSIZE;
    end else if (accept && frame_done) begin
      job.valid = 1'b1;
      job.kind  = (rx_byte == end_mark) ? lfd_pkg::KIND_FRAME : lfd_pkg::KIND_BAD_END;
    end
  end

  assign job_last_addr = last_addr;

  // phase, byte count and length
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      byte_count <= '0;
      last_addr  <= '0;
      len_lo     <= '0;
    end else if (accept) begin
      case (phase)
        PH_HUNT: begin
          if (rx_byte == start_mark) begin
            phase      <= PH_LEN_LO;
            byte_count <= byte_count + AW'(1);
          end
        end
        PH_LEN_LO: begin
          len_lo     <= rx_byte;
          phase      <= PH_LEN_HI;
          byte_count <= byte_count + AW'(1);
        end
        PH_LEN_HI: begin
          if (oversize) begin
            phase      <= PH_HUNT;
            byte_count <= '0;
          end else begin
            last_addr  <= AW'(len_lo + lfd_pkg::HDR_END_OFFSET);
            phase      <= PH_BODY;
            byte_count <= byte_count + AW'(1);
          end
        end
        PH_BODY: begin
          if (frame_done) begin
            phase      <= PH_HUNT;
            byte_count <= '0;
          end else begin
            byte_count <= byte_count + AW'(1);
          end
        end
        default: begin
          phase      <= PH_HUNT;
          byte_count <= '0;
        end
      endcase
    end
  end

  // the count never runs past the end byte of the frame
  `LFD_ASSERT_NOW(a_count_in_frame, clk, rst, phase == PH_BODY, byte_count <= last_addr)

endmodule

FILE: hw/rtl/lfd_emitter.sv
`timescale 1ns / 1ps
`include "length_framed_deframer_macros.svh"
// ----------------------------------------------------------------------------
// lfd_emitter
// Drains a finished frame from the frame store into the output register,
// or sends a single drop status beat.
// ----------------------------------------------------------------------------
module lfd_emitter #(
  parameter int unsigned FRAME_BYTES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lfd_pkg::job_t                  job,
  input  logic [$clog2(FRAME_BYTES)-1:0] job_last_addr,
  output logic                           busy,
  output logic                           rd_en,
  output logic [$clog2(FRAME_BYTES)-1:0] rd_addr,
  input  logic [7:0]                     rd_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     kind,
  output logic [7:0]                     data,
  output logic                           last
);

  localparam int unsigned AW = $clog2(FRAME_BYTES);

  logic           job_active;
  lfd_pkg::kind_t job_kind;
  logic [AW-1:0]  last_addr;
  logic           inflight;
  logic           inflight_last;
  logic           out_free;
  logic           issue;
  logic           status_go;

  // one read in flight at most; it is issued only when the output frees up
  always_comb begin
    out_free  = !out_valid || !out_stall;
    issue     = job_active && (job_kind == lfd_pkg::KIND_FRAME) && !inflight && out_free;
    status_go = job_active && (job_kind != lfd_pkg::KIND_FRAME) && !inflight && out_free;
  end

  assign busy  = job_active;
  assign rd_en = issue;

  // job, read pointer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      job_active    <= 1'b0;
      inflight      <= 1'b0;
      inflight_last <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (job.valid) begin
        job_active <= 1'b1;
        job_kind   <= job.kind;
        rd_addr    <= '0;
        last_addr  <= job_last_addr;
      end else if (issue) begin
        rd_addr <= rd_addr + AW'(1);
        if (rd_addr == last_addr) begin
          job_active <= 1'b0;
        end
      end else if (status_go) begin
        job_active <= 1'b0;
      end

      inflight      <= issue;
      inflight_last <= issue && (rd_addr == last_addr);

      if (inflight) begin
        out_valid <= 1'b1;
        kind      <= lfd_pkg::KIND_FRAME;
        data      <= rd_data;
        last      <= inflight_last;
      end else if (status_go) begin
        out_valid <= 1'b1;
        kind      <= job_kind;
        data      <= 8'd0;
        last      <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  // read data always lands in the output register
  `LFD_ASSERT_NEXT(a_read_fills_out, clk, rst, inflight, out_valid)
  // reads are spaced so the output register is never overrun
  `LFD_ASSERT_NEXT(a_single_inflight, clk, rst, inflight, !inflight)
  // a new job only arrives while the emitter is idle
  `LFD_ASSERT_NOW(a_job_when_idle, clk, rst, job.valid, !job_active)

endmodule

FILE: hw/rtl/length_framed_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_framed_deframer
// Start / length / end byte deframer with a frame store memory.
// ----------------------------------------------------------------------------
// Input beats (in_valid, in_stall, rx_byte) carry one received byte each.
// Bytes are dropped until start_mark; then a little-endian 16-bit length L
// follows, L+1 payload bytes and an end byte. The whole frame is written to
// the frame store as it arrives, one byte a cycle when not stalled.
// Output beats (out_valid, out_stall, kind, data, last): a good frame is
// replayed from the store byte by byte, last on the end byte; a bad end
// mark or a length over the limit gives one status beat with last set.
// A status beat passes from the deciding byte through the job register to
// the output register; the first frame byte passes through the job
// register, the store read and the output register. A frame drains with
// one store read outstanding at most. Input is stalled while a frame or
// status waits to go out, otherwise one byte is taken every cycle.
// out_stall holds the output register and, through it, the drain.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready. Reset returns marks and limit to their defaults and hunting;
// the frame store is not cleared.
// ----------------------------------------------------------------------------
module length_framed_deframer #(
  parameter int unsigned FRAME_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    kind,
  output logic [7:0]                    data,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  localparam int unsigned AW = $clog2(FRAME_BYTES);

  logic [7:0]    start_mark;
  logic [7:0]    end_mark;
  logic [5:0]    max_payload;
  logic          accept;
  logic          busy;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  lfd_pkg::job_t job;
  logic [AW-1:0] job_last_addr;

  // input handshake
  assign in_stall  = busy;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_mark  <= lfd_pkg::START_MARK_RST;
      end_mark    <= lfd_pkg::END_MARK_RST;
      max_payload <= lfd_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lfd_pkg::CFG_START_MARK:  start_mark  <= cfg_data;
        lfd_pkg::CFG_END_MARK:    end_mark    <= cfg_data;
        lfd_pkg::CFG_MAX_PAYLOAD: max_payload <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // byte parser
  lfd_parser #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .rx_byte      (rx_byte),
    .start_mark   (start_mark),
    .end_mark     (end_mark),
    .max_payload  (max_payload),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .job          (job),
    .job_last_addr(job_last_addr)
  );

  // frame store
  lfd_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // result emitter
  lfd_emitter #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_emitter (
    .clk          (clk),
    .rst          (rst),
    .job          (job),
    .job_last_addr(job_last_addr),
    .busy         (busy),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .data         (data),
    .last         (last)
  );

endmodule
